// File: rtl/core/cbez_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbez_pkg
// Shared constants for the cubic Bezier easing evaluator.
// ----------------------------------------------------------------------------
package cbez_pkg;

   localparam int ITERATIONS_DEFAULT    = 17;
   localparam int FRACTION_BITS_DEFAULT = 16;
   localparam int TOL_DEFAULT           = 1;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;
   localparam int IO_W        = 17;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIRST_X  = 2'd0,
      CSR_FIRST_Y  = 2'd1,
      CSR_SECOND_X = 2'd2,
      CSR_SECOND_Y = 2'd3
   } csr_index_type;

   localparam logic [CSR_DATA_W-1:0] FIRST_RESET  = 7'd0;
   localparam logic [CSR_DATA_W-1:0] SECOND_RESET = 7'd127;
   localparam logic [IO_W-1:0]       IO_ONE       = 17'd65536;

endpackage

// File: rtl/core/cbez_curve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbez_curve
// Six-stage evaluator of one Bezier coordinate at parameter t, rounded
// half up after the division by 127, clamped to one. Sideband rides along.
// ----------------------------------------------------------------------------
module cbez_curve #(
   parameter int FB     = cbez_pkg::FRACTION_BITS_DEFAULT,
   parameter int SIDE_W = 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic [FB:0]                        in_t,
   input  logic [cbez_pkg::CSR_DATA_W-1:0]    p1,
   input  logic [cbez_pkg::CSR_DATA_W-1:0]    p2,
   input  logic [SIDE_W-1:0]                  in_side,
   output logic                               out_valid,
   output logic [FB:0]                        out_t,
   output logic [FB:0]                        out_v,
   output logic [SIDE_W-1:0]                  out_side
);

   localparam int TW   = FB + 1;
   localparam int PW   = 2 * TW;
   localparam int MPW  = PW + 7;
   localparam int SUMW = PW + 10;
   localparam int WW   = FB + 10;
   localparam int SH   = WW + 7;
   localparam int MW   = WW + 1;
   localparam int RPW  = WW + MW;
   localparam int QW   = FB + 3;
   localparam logic [TW-1:0]   ONE   = {1'b1, {FB{1'b0}}};
   localparam logic [SUMW-1:0] HALF  = SUMW'(127) << (FB - 1);
   localparam logic [MW-1:0]   RECIP = MW'((64'd1 << SH) / 64'd127);

   logic              v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic [SIDE_W-1:0] side1_ff, side2_ff, side3_ff, side4_ff, side5_ff, side6_ff;
   logic [TW-1:0]     t1_ff, t2_ff, t3_ff, t4_ff, t5_ff, t6_ff;
   logic [TW-1:0]     u1_ff, tt1_ff, uu1_ff;
   logic [TW-1:0]     ttt2_ff, ttt3_ff;
   logic [PW-1:0]     a2_ff, b2_ff;
   logic [MPW-1:0]    s1_3_ff, s2_3_ff;
   logic [WW-1:0]     w4_ff, w5_ff;
   logic [QW-1:0]     q5_ff;
   logic [TW-1:0]     val6_ff;

   logic [TW-1:0]   u_in;
   logic [PW-1:0]   sq_t, sq_u, cube, a_in, b_in;
   logic [SUMW-1:0] sum_in;
   logic [RPW-1:0]  prod_in;
   logic [WW:0]     q_ext, rem_in;
   logic [QW-1:0]   q_fix;
   logic [TW-1:0]   val_in;

   always_comb begin
      u_in    = ONE - in_t;
      sq_t    = PW'(in_t) * PW'(in_t);
      sq_u    = PW'(u_in) * PW'(u_in);
      cube    = PW'(tt1_ff) * PW'(t1_ff);
      a_in    = PW'(t1_ff) * PW'(uu1_ff);
      b_in    = PW'(tt1_ff) * PW'(u1_ff);
      sum_in  = ((SUMW'(ttt3_ff) * SUMW'(127)) << FB)
                + (SUMW'(s1_3_ff) << 1) + SUMW'(s1_3_ff)
                + (SUMW'(s2_3_ff) << 1) + SUMW'(s2_3_ff) + HALF;
      prod_in = RPW'(w4_ff) * RPW'(RECIP);
      q_ext   = (WW+1)'(q5_ff);
      rem_in  = (WW+1)'(w5_ff) - ((q_ext << 7) - q_ext);
      q_fix   = (rem_in >= (WW+1)'(127)) ? q5_ff + QW'(1) : q5_ff;
      val_in  = (q_fix > QW'(ONE)) ? ONE : q_fix[TW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      side1_ff <= in_side;
      t1_ff    <= in_t;
      u1_ff    <= u_in;
      tt1_ff   <= sq_t[FB +: TW];
      uu1_ff   <= sq_u[FB +: TW];

      side2_ff <= side1_ff;
      t2_ff    <= t1_ff;
      ttt2_ff  <= cube[FB +: TW];
      a2_ff    <= a_in;
      b2_ff    <= b_in;

      side3_ff <= side2_ff;
      t3_ff    <= t2_ff;
      ttt3_ff  <= ttt2_ff;
      s1_3_ff  <= MPW'(a2_ff) * MPW'(p1);
      s2_3_ff  <= MPW'(b2_ff) * MPW'(p2);

      side4_ff <= side3_ff;
      t4_ff    <= t3_ff;
      w4_ff    <= sum_in[FB +: WW];

      side5_ff <= side4_ff;
      t5_ff    <= t4_ff;
      w5_ff    <= w4_ff;
      q5_ff    <= prod_in[SH +: QW];

      side6_ff <= side5_ff;
      t6_ff    <= t5_ff;
      val6_ff  <= val_in;
   end

   assign out_valid = v6_ff;
   assign out_t     = t6_ff;
   assign out_v     = val6_ff;
   assign out_side  = side6_ff;

endmodule

// File: rtl/core/cbez_bisect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbez_bisect
// One registered bisection step: test the tolerance, narrow the bracket and
// form the next midpoint. A finished transaction passes through unchanged.
// ----------------------------------------------------------------------------
module cbez_bisect #(
   parameter int FB  = cbez_pkg::FRACTION_BITS_DEFAULT,
   parameter int TOL = cbez_pkg::TOL_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [FB:0]       in_t,
   input  logic [FB:0]       in_x,
   input  logic [3*FB+4:0]   in_side,
   output logic              out_valid,
   output logic [FB:0]       out_t,
   output logic [3*FB+4:0]   out_side
);

   localparam int TW = FB + 1;

   logic            valid_ff;
   logic [TW-1:0]   t_ff;
   logic [3*TW+1:0] side_ff;

   logic [TW-1:0] time_q, start_q, stop_q, diff, start_in, stop_in, t_in;
   logic          done, conv, done_in, conv_in;
   logic [TW:0]   mid_sum;

   always_comb begin
      time_q  = in_side[3*TW+1 -: TW];
      start_q = in_side[2*TW+1 -: TW];
      stop_q  = in_side[TW+1 -: TW];
      done    = in_side[1];
      conv    = in_side[0];
      diff    = (time_q > in_x) ? time_q - in_x : in_x - time_q;
      start_in = start_q;
      stop_in  = stop_q;
      t_in     = in_t;
      done_in  = done;
      conv_in  = conv;
      mid_sum  = '0;
      if (!done) begin
         if ((TW+5)'(diff) <= (TW+5)'(TOL)) begin
            done_in = 1'b1;
            conv_in = 1'b1;
         end else begin
            if (time_q < in_x) begin
               stop_in = in_t;
            end else begin
               start_in = in_t;
            end
            mid_sum = (TW+1)'(start_in) + (TW+1)'(stop_in);
            t_in    = mid_sum[TW:1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      t_ff    <= t_in;
      side_ff <= {time_q, start_in, stop_in, done_in, conv_in};
   end

   assign out_valid = valid_ff;
   assign out_t     = t_ff;
   assign out_side  = side_ff;

endmodule

// File: rtl/core/cubic_bezier_easing_eval_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_easing_eval_core
// Throughput: one transaction per cycle; busy stays low. The pipeline is fully
// unrolled, with curve units for the first midpoint, each bisection step and y.
// Results appear on rsp_valid for one cycle; the receiver cannot stall.
// Reset: synchronous, clears valid bits and loads default control points.
// ----------------------------------------------------------------------------
module cubic_bezier_easing_eval_core #(
   parameter int ITERATIONS    = cbez_pkg::ITERATIONS_DEFAULT,
   parameter int FRACTION_BITS = cbez_pkg::FRACTION_BITS_DEFAULT,
   parameter int TOL           = cbez_pkg::TOL_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [cbez_pkg::IO_W-1:0]           req_time_fraction,
   output logic                                rsp_valid,
   output logic [cbez_pkg::IO_W-1:0]           rsp_eased_value,
   output logic [cbez_pkg::IO_W-1:0]           rsp_curve_parameter,
   output logic                                rsp_converged,
   input  logic                                csr_write_enable,
   input  logic [cbez_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cbez_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int FB = FRACTION_BITS;
   localparam int TW = FB + 1;
   localparam int SW = 3 * TW + 2;
   localparam int IW = cbez_pkg::IO_W;
   localparam logic [TW-1:0] ONE  = {1'b1, {FB{1'b0}}};
   localparam logic [TW-1:0] HALF = ONE >> 1;

   logic [cbez_pkg::CSR_DATA_W-1:0] p1x_ff, p1y_ff, p2x_ff, p2y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1x_ff <= cbez_pkg::FIRST_RESET;
         p1y_ff <= cbez_pkg::FIRST_RESET;
         p2x_ff <= cbez_pkg::SECOND_RESET;
         p2y_ff <= cbez_pkg::SECOND_RESET;
      end else if (csr_write_enable) begin
         case (cbez_pkg::csr_index_type'(csr_index))
            cbez_pkg::CSR_FIRST_X:  p1x_ff <= csr_write_data;
            cbez_pkg::CSR_FIRST_Y:  p1y_ff <= csr_write_data;
            cbez_pkg::CSR_SECOND_X: p2x_ff <= csr_write_data;
            cbez_pkg::CSR_SECOND_Y: p2y_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic [IW-1:0] time_sat;
   logic [TW-1:0] time_int;
   logic          in_valid_ff;
   logic [TW-1:0] time_ff;

   assign time_sat = (req_time_fraction > cbez_pkg::IO_ONE) ? cbez_pkg::IO_ONE
                                                            : req_time_fraction;
   generate
      if (FB >= 16) begin : g_from_wide
         assign time_int = TW'(time_sat) << (FB - 16);
      end else begin : g_from_narrow
         assign time_int = TW'(time_sat >> (16 - FB));
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      time_ff <= time_int;
   end

   logic          c_vld  [ITERATIONS+1];
   logic [TW-1:0] c_t    [ITERATIONS+1];
   logic [TW-1:0] c_x    [ITERATIONS+1];
   logic [SW-1:0] c_side [ITERATIONS+1];
   logic          b_vld  [ITERATIONS];
   logic [TW-1:0] b_t    [ITERATIONS];
   logic [SW-1:0] b_side [ITERATIONS];

   cbez_curve #(.FB(FB), .SIDE_W(SW)) u_curve_first (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_t      (HALF),
      .p1        (p1x_ff),
      .p2        (p2x_ff),
      .in_side   ({time_ff, {TW{1'b0}}, ONE, 1'b0, 1'b0}),
      .out_valid (c_vld[0]),
      .out_t     (c_t[0]),
      .out_v     (c_x[0]),
      .out_side  (c_side[0])
   );

   generate
      for (genvar i = 0; i < ITERATIONS; i++) begin : g_step
         cbez_bisect #(.FB(FB), .TOL(TOL)) u_bisect (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (c_vld[i]),
            .in_t      (c_t[i]),
            .in_x      (c_x[i]),
            .in_side   (c_side[i]),
            .out_valid (b_vld[i]),
            .out_t     (b_t[i]),
            .out_side  (b_side[i])
         );
         cbez_curve #(.FB(FB), .SIDE_W(SW)) u_curve (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (b_vld[i]),
            .in_t      (b_t[i]),
            .p1        (p1x_ff),
            .p2        (p2x_ff),
            .in_side   (b_side[i]),
            .out_valid (c_vld[i+1]),
            .out_t     (c_t[i+1]),
            .out_v     (c_x[i+1]),
            .out_side  (c_side[i+1])
         );
      end
   endgenerate

   logic [TW-1:0] last_time, last_x, last_diff;
   logic          last_conv;

   always_comb begin
      last_time = c_side[ITERATIONS][SW-1 -: TW];
      last_x    = c_x[ITERATIONS];
      last_diff = (last_time > last_x) ? last_time - last_x : last_x - last_time;
      last_conv = c_side[ITERATIONS][0]
                  | (~c_side[ITERATIONS][1] & ((TW+5)'(last_diff) <= (TW+5)'(TOL)));
   end

   logic          y_vld;
   logic [TW-1:0] y_t, y_v;
   logic          y_conv;

   cbez_curve #(.FB(FB), .SIDE_W(1)) u_curve_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_vld[ITERATIONS]),
      .in_t      (c_t[ITERATIONS]),
      .p1        (p1y_ff),
      .p2        (p2y_ff),
      .in_side   (last_conv),
      .out_valid (y_vld),
      .out_t     (y_t),
      .out_v     (y_v),
      .out_side  (y_conv)
   );

   logic [IW-1:0] y_io, t_io;

   generate
      if (FB >= 16) begin : g_to_wide
         assign y_io = IW'(y_v >> (FB - 16));
         assign t_io = IW'(y_t >> (FB - 16));
      end else begin : g_to_narrow
         assign y_io = IW'(y_v) << (16 - FB);
         assign t_io = IW'(y_t) << (16 - FB);
      end
   endgenerate

   logic          rsp_valid_ff;
   logic [IW-1:0] rsp_value_ff, rsp_param_ff;
   logic          rsp_conv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= y_vld;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= y_io;
      rsp_param_ff <= t_io;
      rsp_conv_ff  <= y_conv;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_eased_value     = rsp_value_ff;
   assign rsp_curve_parameter = rsp_param_ff;
   assign rsp_converged       = rsp_conv_ff;

endmodule
